// ===== rtl/bdq_pkg.sv =====
// Shared types and constants for the bounded deque with insert.
// Holds operation codes, status codes, FSM states and default sizes.
// No dependencies.
`default_nettype none

package bdq_pkg;

    // Default sizing for the top-level parameters
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the beats
    localparam int OP_W   = 3;
    localparam int POS_W  = 4;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4,
        OP_INSERT     = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_INS_RD,
        S_INS_WR
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/bdq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bounded_deque_with_insert_core.sv =====
// Bounded double-ended queue with insert-after, top level.
// Depends on bdq_pkg and bdq_ram.
`default_nettype none

// Ordered list of up to DEPTH elements kept in a circular RAM with a front
// pointer and an element count. Each input beat carries one operation (push
// front/back, pop front/back, read at position, insert after position) and
// produces exactly one result beat with data, status and the new count.
// Pushes, pops, reads, failed operations and unknown codes pass through
// the accept cycle, which issues the RAM access, and a response cycle that
// loads the output register. Insert after position p moves every element
// behind p back by one slot through the single RAM read port, with a read
// state and a write state for each. A held result on the output does not
// block the next beat from being accepted; the block only waits when a new
// result is ready and the previous one has not yet been taken.

module bounded_deque_with_insert_core #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [bdq_pkg::OP_W-1:0]     s_operation,
    input  wire logic [bdq_pkg::POS_W-1:0]    s_position,
    input  wire logic [bdq_pkg::VAL_W-1:0]    s_value,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [bdq_pkg::VAL_W-1:0]    m_data,
    output logic      [bdq_pkg::STAT_W-1:0]   m_status,
    output logic      [bdq_pkg::CNT_W-1:0]    m_count
);

    import bdq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int VW   = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

    // Physical slot of a logical offset from the front (wraps once at most)
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [CW-1:0] offs);
        logic [SW-1:0] sum;
        sum = SW'(front) + SW'(offs);
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [AW-1:0]         front_reg, front_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    status_t               res_status_reg, res_status_next;
    logic                  res_ram_reg, res_ram_next;
    logic                  m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]      m_data_reg, m_data_next;
    logic [STAT_W-1:0]     m_status_reg, m_status_next;
    logic [CNT_W-1:0]      m_count_reg, m_count_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  in_fire;
    logic                  out_free;
    logic                  load_out;
    logic                  is_full;
    logic                  is_empty;
    logic                  pos_bad;
    logic [DATA_WIDTH-1:0] in_val;
    logic [CW-1:0]         pos_off;
    logic [CW-1:0]         pos1;
    logic [AW-1:0]         front_dec;
    logic [AW-1:0]         front_inc;

    // Element store
    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and list status
    assign s_ready   = (state_reg == S_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign load_out  = (state_reg == S_RESP) && out_free;
    assign is_full   = (count_reg == FULL_CNT);
    assign is_empty  = (count_reg == '0);
    assign pos_bad   = (CMPW'(s_position) >= CMPW'(count_reg));
    assign in_val    = DATA_WIDTH'(s_value[VW-1:0]);
    assign pos_off   = CW'(s_position);
    assign pos1      = CW'(pos_reg) + CW'(1);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + AW'(1);

    // Next state, RAM control and result staging
    always_comb begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_ram_next    = res_ram_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = in_val;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    pos_next        = s_position;
                    val_next        = in_val;
                    res_status_next = ST_OK;
                    res_ram_next    = 1'b0;
                    state_next      = S_RESP;
                    case (s_operation)
                        OP_PUSH_FRONT: begin
                            if (is_full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (is_full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot_of(front_reg, count_reg);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (is_empty) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                ram_re       = 1'b1;
                                ram_raddr    = front_reg;
                                res_ram_next = 1'b1;
                                front_next   = front_inc;
                                count_next   = count_reg - CW'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (is_empty) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                ram_re       = 1'b1;
                                ram_raddr    = slot_of(front_reg, count_reg - CW'(1));
                                res_ram_next = 1'b1;
                                count_next   = count_reg - CW'(1);
                            end
                        end
                        OP_READ: begin
                            if (pos_bad) begin
                                res_status_next = ST_BADPOS;
                            end else begin
                                ram_re       = 1'b1;
                                ram_raddr    = slot_of(front_reg, pos_off);
                                res_ram_next = 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            if (pos_bad) begin
                                res_status_next = ST_BADPOS;
                            end else if (is_full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        default: begin
                            // unknown codes leave the list untouched
                        end
                    endcase
                end
            end

            // Fetch the element one ahead of the hole, or drop the new one in
            S_INS_RD: begin
                if (idx_reg > pos1) begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot_of(front_reg, idx_reg - CW'(1));
                    state_next = S_INS_WR;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_of(front_reg, pos1);
                    ram_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_RESP;
                end
            end

            // Move the fetched element back by one slot
            S_INS_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = slot_of(front_reg, idx_reg);
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg - CW'(1);
                state_next = S_INS_RD;
            end

            // Load the output register once it is free
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = res_ram_reg ? VAL_W'(ram_rdata[VW-1:0]) : '0;
                    m_status_next = res_status_reg;
                    m_count_next  = CNT_W'(count_reg);
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_ram_reg    <= res_ram_next;
        m_data_reg     <= m_data_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;
    assign m_count  = m_count_reg;

    // Count never exceeds the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("element count above capacity");

    // A full status is only reported while the list is full
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && res_status_reg == ST_FULL) |-> (count_reg == FULL_CNT))
        else $error("full status with free space");

    // A pop from the front of a non-empty list moves the front and shrinks the count
    a_pop_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_operation == OP_POP_FRONT && !is_empty)
        |=> (count_reg == $past(count_reg) - CW'(1)) && (front_reg != $past(front_reg)))
        else $error("pop front did not update front and count");

    // The shift pass stays inside the live list and never starts on a full one
    a_ins_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_RD || state_reg == S_INS_WR)
        |-> (count_reg < FULL_CNT) && (idx_reg <= count_reg))
        else $error("insert shift out of range");

endmodule

`default_nettype wire

// ===== tb/bounded_deque_with_insert_core_tb.sv =====
// Self-checking testbench for bounded_deque_with_insert_core.
// Needs bdq_pkg and the core RTL. A shadow deque predicts every result beat,
// random valid/ready gaps and a long output stall exercise the handshakes.
`default_nettype none

module bounded_deque_with_insert_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int RAND_BEATS  = 950;
    localparam int LONG_HOLD   = 80;
    localparam int SETTLE_CYC  = 64;
    localparam int TIMEOUT_NS  = 5_000_000;

    // Codes 6 and 7 have no operation behind them
    localparam logic [OP_W-1:0] OP_UNDEF_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_B = 3'd7;

    // Op mix per phase: fill-heavy, drain-heavy, balanced (columns in op code order)
    localparam int OP_WEIGHT [3][6] = '{
        '{20, 20,  8,  8, 14, 30},
        '{ 6,  6, 30, 30, 14, 14},
        '{15, 15, 15, 15, 20, 20}
    };

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } request_t;

    typedef struct {
        logic [VAL_W-1:0] data;
        status_t          status;
        logic [CNT_W-1:0] count;
    } deque_result_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [OP_W-1:0]    s_operation = '0;
    logic [POS_W-1:0]   s_position  = '0;
    logic [VAL_W-1:0]   s_value     = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [VAL_W-1:0]   m_data;
    logic [STAT_W-1:0]  m_status;
    logic [CNT_W-1:0]   m_count;

    bounded_deque_with_insert_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_position  (s_position),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .m_status    (m_status),
        .m_count     (m_count)
    );

    // Shadow copy of the deque
    logic [VAL_W-1:0] shadow_slots [DEPTH];
    int               shadow_front = 0;
    int               shadow_count = 0;

    request_t         req_q[$];
    deque_result_t    want_q[$];

    int  beats_out   = 0;   // beats put on the input bus
    int  beats_in    = 0;   // beats accepted by the core
    int  results_ok  = 0;
    int  err_count   = 0;
    int  op_hits     [8];
    int  status_hits [4];
    int  tx_gap      = 0;
    int  rx_gap      = 0;
    int  rx_seen     = 0;
    int  hold_left   = 0;
    int  stall_req   = 0;
    int  stall_done  = 0;
    bit  tx_burst    = 1'b0;
    bit  rx_burst    = 1'b0;

    function automatic int slot_of(int offset);
        return (shadow_front + offset) % DEPTH;
    endfunction

    // Apply one request to the shadow deque and return the result it yields
    function automatic deque_result_t deque_apply(logic [OP_W-1:0] op,
                                                  logic [POS_W-1:0] pos,
                                                  logic [VAL_W-1:0] val);
        deque_result_t r;
        int i;
        r.data   = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_slots[shadow_front] = val;
                    shadow_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_slots[slot_of(shadow_count)] = val;
                    shadow_count++;
                end
            end
            OP_POP_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = shadow_slots[shadow_front];
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            end
            OP_POP_BACK: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = shadow_slots[slot_of(shadow_count - 1)];
                    shadow_count--;
                end
            end
            OP_READ: begin
                if (int'(pos) >= shadow_count) r.status = ST_BADPOS;
                else r.data = shadow_slots[slot_of(int'(pos))];
            end
            OP_INSERT: begin
                // position is checked before fullness
                if (int'(pos) >= shadow_count) begin
                    r.status = ST_BADPOS;
                end else if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = shadow_count; i > int'(pos) + 1; i--)
                        shadow_slots[slot_of(i)] = shadow_slots[slot_of(i - 1)];
                    shadow_slots[slot_of(int'(pos) + 1)] = val;
                    shadow_count++;
                end
            end
            default: ;
        endcase
        r.count = CNT_W'(shadow_count);
        return r;
    endfunction

    task automatic queue_beat(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                              logic [VAL_W-1:0] val);
        request_t rq;
        rq.op  = op;
        rq.pos = pos;
        rq.val = val;
        req_q.push_back(rq);
    endtask

    function automatic logic [OP_W-1:0] pick_op(int bias);
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 3) return (r == 0) ? OP_UNDEF_B : OP_UNDEF_A;
        r = $urandom_range(0, 99);
        for (k = 0; k < 5; k++) begin
            if (r < OP_WEIGHT[bias][k]) return OP_W'(k);
            r -= OP_WEIGHT[bias][k];
        end
        return OP_INSERT;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Hold off new phases until the core has answered everything
    task automatic wait_idle();
        while (req_q.size() != 0 || s_valid || want_q.size() != 0)
            @(posedge aclk);
    endtask

    // Clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // Input driver: one beat per request, random gap after each accepted beat outside burst mode
    always @(negedge aclk) begin
        request_t nxt;
        if (aresetn) begin
            if (s_valid && beats_in == beats_out)
                tx_gap = tx_burst ? 0 : $urandom_range(0, 12);
            if (!s_valid || beats_in == beats_out) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    nxt = req_q.pop_front();
                    s_operation <= nxt.op;
                    s_position  <= nxt.pos;
                    s_value     <= nxt.val;
                    s_valid     <= 1'b1;
                    beats_out++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random wait per result outside burst mode, plus the requested long stall
    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_req != stall_done) begin
                stall_done = stall_req;
                hold_left  = LONG_HOLD;
            end
            if (results_ok != rx_seen) begin
                rx_seen = results_ok;
                rx_gap  = rx_burst ? 0 : $urandom_range(0, 12);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: check result beats, then predict for accepted input beats
    always @(posedge aclk) begin
        deque_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_ok++;
                if (want_q.size() == 0) begin
                    $error("unexpected result beat: data %h status %0d count %0d",
                           m_data, m_status, m_count);
                    err_count++;
                end else begin
                    want = want_q.pop_front();
                    status_hits[want.status]++;
                    if (m_data !== want.data) begin
                        $error("data: expected %h, got %h", want.data, m_data);
                        err_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        err_count++;
                    end
                    if (m_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, m_count);
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want_q.push_back(deque_apply(s_operation, s_position, s_value));
                op_hits[s_operation]++;
                beats_in++;
            end
        end
    end

    // Run limit
    initial begin
        #TIMEOUT_NS;
        $display("bounded_deque_with_insert_core_tb: errors");
        $finish;
    end

    // Stimulus
    initial begin
        int counted;
        int len;
        int k;
        int bias;
        logic [OP_W-1:0] op;

        foreach (shadow_slots[i]) shadow_slots[i] = '0;
        foreach (op_hits[i]) op_hits[i] = 0;
        foreach (status_hits[i]) status_hits[i] = 0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty-list errors, unknown codes, edge values and positions
        queue_beat(OP_POP_FRONT,  4'd0,  '0);
        queue_beat(OP_POP_BACK,   4'd15, '1);
        queue_beat(OP_READ,       4'd0,  '0);
        queue_beat(OP_INSERT,     4'd0,  32'h1111_1111);
        queue_beat(OP_UNDEF_A,    4'd5,  32'h5555_5555);
        queue_beat(OP_UNDEF_B,    4'd15, '1);
        queue_beat(OP_PUSH_BACK,  4'd0,  '0);
        queue_beat(OP_PUSH_FRONT, 4'd15, '1);
        queue_beat(OP_PUSH_BACK,  4'd3,  32'hA5A5_A5A5);
        queue_beat(OP_READ,       4'd0,  '0);
        queue_beat(OP_READ,       4'd2,  '0);
        queue_beat(OP_READ,       4'd3,  '1);
        queue_beat(OP_READ,       4'd15, '0);
        queue_beat(OP_INSERT,     4'd0,  32'h1234_5678);
        queue_beat(OP_INSERT,     4'd3,  32'h5A5A_5A5A);
        queue_beat(OP_INSERT,     4'd9,  32'hDEAD_BEEF);
        queue_beat(OP_READ,       4'd1,  '0);
        queue_beat(OP_POP_BACK,   4'd0,  '0);
        queue_beat(OP_POP_FRONT,  4'd0,  '0);
        queue_beat(OP_UNDEF_A,    4'd0,  '0);
        wait_idle();

        // Long output stall with the sender streaming: fills the list and
        // backs the core up, then push/insert at full and reads at the ends
        tx_burst = 1'b1;
        stall_req++;
        for (k = 0; k < 18; k++) queue_beat(OP_PUSH_BACK, POS_W'(k), pick_value());
        queue_beat(OP_PUSH_FRONT, 4'd0,  '1);
        queue_beat(OP_INSERT,     4'd7,  32'h0F0F_0F0F);
        queue_beat(OP_INSERT,     4'd15, '0);
        queue_beat(OP_READ,       4'd15, '0);
        queue_beat(OP_READ,       4'd0,  '0);
        queue_beat(OP_POP_BACK,   4'd0,  '0);
        queue_beat(OP_INSERT,     4'd14, 32'hC3C3_C3C3);
        queue_beat(OP_POP_FRONT,  4'd0,  '0);
        wait_idle();

        // Random phases, each with its own op mix and idle pattern
        counted = 0;
        while (counted < RAND_BEATS) begin
            bias     = $urandom_range(0, 2);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            len      = $urandom_range(20, 60);
            for (k = 0; k < len && counted < RAND_BEATS; k++) begin
                op = pick_op(bias);
                if (op != OP_UNDEF_A && op != OP_UNDEF_B) counted++;
                queue_beat(op, $urandom_range(0, 1) ? POS_W'($urandom_range(0, 15))
                                                    : POS_W'($urandom_range(0, 5)),
                           pick_value());
            end
            if ($urandom_range(0, 2) == 0) wait_idle();
            else while (req_q.size() > 4) @(posedge aclk);
        end

        wait_idle();
        repeat (SETTLE_CYC) @(posedge aclk);
        if (want_q.size() != 0) begin
            $error("%0d expected results never arrived", want_q.size());
            err_count++;
        end

        $display("Ran %0d beats (inserts %0d, reads %0d, unknown codes %0d), %0d results.",
                 beats_in, op_hits[OP_INSERT], op_hits[OP_READ],
                 op_hits[OP_UNDEF_A] + op_hits[OP_UNDEF_B], results_ok);
        $display("Statuses seen: ok %0d, empty %0d, bad position %0d, full %0d.",
                 status_hits[ST_OK], status_hits[ST_EMPTY],
                 status_hits[ST_BADPOS], status_hits[ST_FULL]);
        if (err_count == 0) begin
            $display("bounded_deque_with_insert_core_tb: clean");
        end else begin
            $display("bounded_deque_with_insert_core_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
